// ----- rtl/pkr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkr_pkg
// shared types and constants of the poker test pattern counter
// ----------------------------------------------------------------------------
package pkr_pkg;

  // request and result widths
  localparam int VALUE_W     = 14;
  localparam int IN_TDATA_W  = 16;
  localparam int COUNT_W     = 20;
  localparam int NUM_CLS     = 6;
  localparam int OUT_TDATA_W = NUM_CLS * COUNT_W;

  // default tally width
  localparam int TALLY_WIDTH_DEF = 20;

  // largest classed value per mode
  localparam logic [VALUE_W-1:0] MAX_3DIGIT = VALUE_W'(999);
  localparam logic [VALUE_W-1:0] MAX_4DIGIT = VALUE_W'(9999);

  // reciprocal constants, exact for every 14-bit value
  localparam int RECIP10   = 52429;
  localparam int SHIFT10   = 19;
  localparam int RECIP100  = 5243;
  localparam int SHIFT100  = 19;
  localparam int RECIP1000 = 8389;
  localparam int SHIFT1000 = 23;

  // quotient widths for a 14-bit value
  localparam int Q10_W   = 11;
  localparam int Q100_W  = 8;
  localparam int Q1000_W = 5;
  localparam int PROD_W  = 30;

  typedef logic [3:0] digit_t;

  // class codes, in result field order
  typedef enum logic [2:0] {
    CLS_ALL_SAME,
    CLS_THREE_SAME,
    CLS_TWO_PAIRS,
    CLS_ONE_PAIR,
    CLS_ALL_DIFF,
    CLS_OUT_OF_RANGE
  } cls_t;

  // classified request handed to the tally stage
  typedef struct packed {
    logic valid;
    logic last;
    cls_t cls;
  } cls_stage_t;

endpackage

// ----- rtl/pkr_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkr_classify
// two-stage digit split and poker hand classification
// ----------------------------------------------------------------------------
module pkr_classify import pkr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_last,
  input  logic               in_mode,
  output cls_stage_t         res
);

  // quotient stage
  logic               q_valid;
  logic               q_last;
  logic               q_mode;
  logic [VALUE_W-1:0] q_value;
  logic [Q10_W-1:0]   q10;
  logic [Q100_W-1:0]  q100;
  logic [Q1000_W-1:0] q1000;

  logic [PROD_W-1:0] p10;
  logic [PROD_W-1:0] p100;
  logic [PROD_W-1:0] p1000;

  assign p10   = PROD_W'(in_value) * PROD_W'(RECIP10);
  assign p100  = PROD_W'(in_value) * PROD_W'(RECIP100);
  assign p1000 = PROD_W'(in_value) * PROD_W'(RECIP1000);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_last  <= in_last;
      q_mode  <= in_mode;
      q_value <= in_value;
      q10     <= Q10_W'(p10 >> SHIFT10);
      q100    <= Q100_W'(p100 >> SHIFT100);
      q1000   <= Q1000_W'(p1000 >> SHIFT1000);
    end
  end

  // digits from neighboring quotients
  logic [VALUE_W-1:0] r0;
  logic [Q10_W-1:0]   r1;
  logic [Q100_W-1:0]  r2;
  digit_t             d0, d1, d2, d3;

  assign r0 = q_value - VALUE_W'(q10) * VALUE_W'(10);
  assign r1 = q10 - Q10_W'(q100) * Q10_W'(10);
  assign r2 = q100 - Q100_W'(q1000) * Q100_W'(10);
  assign d0 = r0[3:0];
  assign d1 = r1[3:0];
  assign d2 = r2[3:0];
  assign d3 = q1000[3:0];

  logic [1:0] n3;
  logic [2:0] n4;
  cls_t       cls_next;

  always_comb begin
    n3 = 2'(d2 == d1) + 2'(d1 == d0) + 2'(d2 == d0);
    n4 = 3'(d3 == d2) + 3'(d3 == d1) + 3'(d3 == d0)
       + 3'(d2 == d1) + 3'(d2 == d0) + 3'(d1 == d0);
    cls_next = CLS_ALL_DIFF;
    if (!q_mode) begin
      if (q_value > MAX_3DIGIT) begin
        cls_next = CLS_OUT_OF_RANGE;
      end else begin
        case (n3)
          2'd3:    cls_next = CLS_ALL_SAME;
          2'd1:    cls_next = CLS_ONE_PAIR;
          default: cls_next = CLS_ALL_DIFF;
        endcase
      end
    end else begin
      if (q_value > MAX_4DIGIT) begin
        cls_next = CLS_OUT_OF_RANGE;
      end else begin
        case (n4)
          3'd6:    cls_next = CLS_ALL_SAME;
          3'd3:    cls_next = CLS_THREE_SAME;
          3'd2:    cls_next = CLS_TWO_PAIRS;
          3'd1:    cls_next = CLS_ONE_PAIR;
          default: cls_next = CLS_ALL_DIFF;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.last <= q_last;
      res.cls  <= cls_next;
    end
  end

endmodule

// ----- rtl/poker_test_pattern_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poker_test_pattern_counter
// poker test tally of decimal digit patterns over batches of values
// ----------------------------------------------------------------------------
// Takes one value per clock on the slave stream and classes its three or four
// decimal digits (leading zeros included, chosen by digit_mode) as all same,
// three same, two pairs, one pair or all different; values above 999 or 9999
// are counted as out of range instead. Each class has a saturating tally of
// TALLY_WIDTH bits. The request marked with tlast is tallied too, then one
// result with all six counts leaves on the master stream and the tallies
// clear. Sustained rate is one request per cycle while nothing stalls; a
// last request passes the input register, quotient register and class
// register, then the tally and result register. The single output
// register is the only place a result can wait: while it is full and not
// taken, a further last-marked request reaching the tally stage stalls the
// pipe, and other requests keep flowing. digit_mode is sampled with each
// request; write it only between batches while the block is idle.
// ----------------------------------------------------------------------------
module poker_test_pattern_counter import pkr_pkg::*; #(
  parameter int TALLY_WIDTH = TALLY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration: bit 0 digit_mode
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_data,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [13:0] value, rest zero
  input  logic                   s_axis_tlast,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // all_same, three_same,
                                                // two_pairs, one_pair,
                                                // all_different,
                                                // out_of_range; 20 bits each
);

  localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = {TALLY_WIDTH{1'b1}};

  // mode register, always ready
  logic digit_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_mode <= 1'b0;
    end else if (cfg_valid) begin
      digit_mode <= cfg_data[0];
    end
  end

  // pipe control: only a last request meeting a blocked output holds things
  cls_stage_t res;
  logic       stall;
  logic       en;

  assign stall         = res.valid && res.last && m_axis_tvalid && !m_axis_tready;
  assign en            = !stall;
  assign s_axis_tready = en;

  // input register
  logic               in_valid;
  logic [VALUE_W-1:0] in_value;
  logic               in_last;
  logic               in_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (en) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_value <= s_axis_tdata[VALUE_W-1:0];
      in_last  <= s_axis_tlast;
      in_mode  <= digit_mode;
    end
  end

  // digit split and class decision
  pkr_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_value (in_value),
    .in_last  (in_last),
    .in_mode  (in_mode),
    .res      (res)
  );

  // saturating tallies, one per class
  logic [TALLY_WIDTH-1:0] tally      [NUM_CLS];
  logic [TALLY_WIDTH-1:0] tally_next [NUM_CLS];

  always_comb begin
    for (int i = 0; i < NUM_CLS; i++) begin
      if (res.valid && res.cls == cls_t'(3'(i)) && tally[i] != TALLY_MAX) begin
        tally_next[i] = tally[i] + TALLY_WIDTH'(1);
      end else begin
        tally_next[i] = tally[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLS; i++) begin
        tally[i] <= '0;
      end
    end else if (en && res.valid) begin
      for (int i = 0; i < NUM_CLS; i++) begin
        // a finished batch restarts from zero
        tally[i] <= res.last ? '0 : tally_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en && res.valid && res.last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && res.valid && res.last) begin
      for (int i = 0; i < NUM_CLS; i++) begin
        m_axis_tdata[i*COUNT_W +: COUNT_W] <= COUNT_W'(tally_next[i]);
      end
    end
  end

endmodule

// ----- rtl/pkr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkr_checker
// port-level checks of the poker test pattern counter
// ----------------------------------------------------------------------------
module pkr_checker import pkr_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // batch ends taken on the request side and not yet taken as results
  logic [3:0] batches_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      batches_open <= '0;
    end else begin
      batches_open <= batches_open
                    + 4'(s_axis_tvalid && s_axis_tready && s_axis_tlast)
                    - 4'(m_axis_tvalid && m_axis_tready);
    end
  end

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a waiting result holds still
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a result needs the input, quotient and class registers filled after reset
  a_pipe_depth: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3))
    else $error("result too soon after reset");

  // a shown result needs a last request taken and not yet answered
  a_needs_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> batches_open != 4'd0)
    else $error("result without a batch end");

endmodule

bind poker_test_pattern_counter pkr_checker u_pkr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the poker test pattern counter
// ----------------------------------------------------------------------------
// Streams batches of values into the counter and checks every count of every
// result against an in-bench tally of digit patterns. It starts with a short
// directed run: all-zero and all-one values, the range limits of both modes,
// every digit pattern, last on an out-of-range value, and the reset mode.
// Random batches follow. Many values use digits from a small pool so that
// repeats are common; the rest are range edges, uniform or 14-bit noise. The
// sender works in bursts with gaps, the receiver stalls in changing styles,
// and the mode register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import pkr_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 5;
  localparam int TARGET_REQUESTS = 1100;
  localparam int SETTLE_CYCLES   = 10;     // pipe: input, quotient, class and result registers
  localparam int CYCLE_LIMIT     = 200000;

  // one result: counts in class order, class 0 in the lowest bits
  typedef logic [NUM_CLS-1:0][COUNT_W-1:0] count_set_t;

  // running tally of digit patterns and the results it predicts
  class poker_tally_board;
    logic [TALLY_WIDTH_DEF-1:0] tally [NUM_CLS];
    bit                         four_digit;
    count_set_t                 expected_counts [$];
    int                         mismatches;
    int                         requests_seen;
    int                         results_seen;
    int                         class_hits [NUM_CLS];

    function new();
      clear_tallies();
      four_digit = 1'b0;
      mismatches = 0;
      requests_seen = 0;
      results_seen = 0;
      foreach (class_hits[i]) class_hits[i] = 0;
    endfunction

    function void clear_tallies();
      foreach (tally[i]) tally[i] = '0;
    endfunction

    function void set_mode(bit m);
      four_digit = m;
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction

    function cls_t classify(logic [VALUE_W-1:0] v);
      int a, b, c, d, n;
      if (!four_digit) begin
        if (v > MAX_3DIGIT) return CLS_OUT_OF_RANGE;
        a = int'(v) / 100;
        b = (int'(v) / 10) % 10;
        c = int'(v) % 10;
        n = int'(a == b) + int'(b == c) + int'(a == c);
        if (n == 3) return CLS_ALL_SAME;
        if (n == 1) return CLS_ONE_PAIR;
        return CLS_ALL_DIFF;
      end
      if (v > MAX_4DIGIT) return CLS_OUT_OF_RANGE;
      a = int'(v) / 1000;
      b = (int'(v) / 100) % 10;
      c = (int'(v) / 10) % 10;
      d = int'(v) % 10;
      // equal pairs among the six digit pairs
      n = int'(a == b) + int'(a == c) + int'(a == d)
        + int'(b == c) + int'(b == d) + int'(c == d);
      case (n)
        6:       return CLS_ALL_SAME;
        3:       return CLS_THREE_SAME;
        2:       return CLS_TWO_PAIRS;
        1:       return CLS_ONE_PAIR;
        default: return CLS_ALL_DIFF;
      endcase
    endfunction

    function void note_request(logic [VALUE_W-1:0] v, bit last);
      cls_t       c;
      count_set_t snap;
      c = classify(v);
      if (tally[int'(c)] != '1) tally[int'(c)]++;
      class_hits[int'(c)]++;
      requests_seen++;
      if (last) begin
        for (int i = 0; i < NUM_CLS; i++) snap[i] = COUNT_W'(tally[i]);
        expected_counts.push_back(snap);
        clear_tallies();
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      count_set_t got;
      count_set_t want;
      cls_t       c;
      got = data;
      results_seen++;
      if (expected_counts.size() == 0) begin
        $error("result with no request batch waiting: tdata %h", data);
        mismatches++;
        return;
      end
      want = expected_counts.pop_front();
      for (int i = 0; i < NUM_CLS; i++) begin
        c = cls_t'(i);
        if (got[i] !== want[i]) begin
          $error("field %s expected %0d actual %0d", c.name(), want[i], got[i]);
          mismatches++;
        end
      end
    endfunction
  endclass

  // dut ports, all inputs known from time zero
  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [0:0]             cfg_data      = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [13:0] value, rest zero
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // all_same, three_same,
                                                // two_pairs, one_pair,
                                                // all_different,
                                                // out_of_range; 20 bits each

  poker_tally_board board = new();

  int cycle_count   = 0;
  int burst_left    = 0;
  int stall_left    = 0;
  int stall_style   = 0;
  int mode_phases   = 0;

  poker_test_pattern_counter #(
    .TALLY_WIDTH(TALLY_WIDTH_DEF)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // runaway guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: every so often pick a new stall style and hold it a while
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_style)
      0:       m_axis_tready <= 1'b1;                          // never stalls
      1:       m_axis_tready <= 1'($urandom_range(0, 1));      // coin flip
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
      default: m_axis_tready <= ~m_axis_tready;                // alternating
    endcase
  end

  // results are taken at the rising edge where tvalid and tready meet
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // drop valid and let the sender idle
  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // one request; valid stays high afterward so bursts run back to back
  task automatic send_req(int v, bit last);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(v);
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(VALUE_W'(v), last);
  endtask

  // request inside a burst; a random gap opens each new burst
  task automatic send_paced(int v, bit last);
    if (burst_left == 0) begin
      idle_sender($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    send_req(v, last);
    burst_left--;
  endtask

  // wait for every expected result, then let the pipe empty
  task automatic drain();
    idle_sender(1);
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    board.set_mode(m);
    mode_phases++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // value mix: digit pool for repeats, range edges, uniform, full 14-bit noise
  function automatic int random_value(bit m);
    int r, x, y, maxv;
    int dig [4];
    maxv = m ? 9999 : 999;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom_range(0, 16383);
    if (r < 20) begin
      case ($urandom_range(0, 3))
        0:       return 0;
        1:       return maxv;
        2:       return maxv + 1;
        default: return 16383;
      endcase
    end
    if (r < 60) begin
      x = $urandom_range(0, 9);
      y = $urandom_range(0, 9);
      foreach (dig[k]) begin
        case ($urandom_range(0, 3))
          0, 1:    dig[k] = x;
          2:       dig[k] = y;
          default: dig[k] = $urandom_range(0, 9);
        endcase
      end
      return m ? dig[0] * 1000 + dig[1] * 100 + dig[2] * 10 + dig[3]
               : dig[0] * 100 + dig[1] * 10 + dig[2];
    end
    return $urandom_range(0, maxv);
  endfunction

  function automatic int batch_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 1;                 // single-request batches stack results
    if (r < 65) return $urandom_range(2, 10);
    return $urandom_range(11, 60);
  endfunction

  initial begin
    bit m;
    int len;
    int batches;
    bit open_end;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // three-digit mode straight out of reset, no register write yet
    send_req(0, 1'b0);       // all same, all bits low
    send_req(777, 1'b0);
    send_req(999, 1'b0);     // top of the three-digit range
    send_req(123, 1'b0);     // all different
    send_req(112, 1'b0);     // one pair in each position
    send_req(211, 1'b0);
    send_req(121, 1'b0);
    send_req(1000, 1'b0);    // just out of range
    send_req(16383, 1'b1);   // all bits high, out of range, closes the batch
    send_req(500, 1'b1);     // single-request batch
    drain();

    // four-digit mode
    write_mode(1'b1);
    send_req(0, 1'b0);
    send_req(9999, 1'b0);    // top of the four-digit range
    send_req(10000, 1'b0);   // just out of range
    send_req(1112, 1'b0);    // three same
    send_req(2111, 1'b0);
    send_req(1122, 1'b0);    // two pairs
    send_req(1212, 1'b0);
    send_req(1123, 1'b0);    // one pair
    send_req(1234, 1'b0);    // all different
    send_req(999, 1'b0);     // leading zero makes three same
    send_req(5555, 1'b1);
    send_req(12000, 1'b1);   // batch closed by an out-of-range value
    drain();

    // back to three digits, then a batch of nothing but rejects
    write_mode(1'b0);
    send_req(1000, 1'b1);
    drain();

    // random phases, each with its own mode setting
    while (board.requests_seen < TARGET_REQUESTS) begin
      m = 1'($urandom_range(0, 1));
      write_mode(m);
      batches = $urandom_range(2, 8);
      // now and then a phase leaves its tallies open across the mode change
      open_end = ($urandom_range(0, 6) == 0);
      for (int b = 0; b < batches; b++) begin
        len = batch_length();
        for (int i = 0; i < len; i++)
          send_paced(random_value(m),
                     (i == len - 1) && !(open_end && b == batches - 1));
      end
      drain();
    end

    // close whatever is still open
    send_req(random_value(board.four_digit), 1'b1);
    drain();

    $display("run covered %0d requests and %0d results over %0d mode writes",
             board.requests_seen, board.results_seen, mode_phases);
    $display("class hits: same %0d, three %0d, pairs %0d, pair %0d, diff %0d, rejected %0d",
             board.class_hits[0], board.class_hits[1], board.class_hits[2],
             board.class_hits[3], board.class_hits[4], board.class_hits[5]);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
